### sv/ealu_pkg.sv
// Shared types and constants for the eight-bit ALU with flags.
`timescale 1ns / 1ps

package ealu_pkg;

  localparam int unsigned InTdataW  = 72;
  localparam int unsigned OutTdataW = 32;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_DAA   = 5'd10,
    OP_CPL   = 5'd11,
    OP_CCF   = 5'd12,
    OP_SCF   = 5'd13,
    OP_RLCA  = 5'd14,
    OP_RLA   = 5'd15,
    OP_RRCA  = 5'd16,
    OP_RRA   = 5'd17,
    OP_ADD16 = 5'd18,
    OP_ADDSP = 5'd19
  } op_e;

  // flag bit positions
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  localparam logic [7:0] DaaLowAdj  = 8'h06;
  localparam logic [7:0] DaaHighAdj = 8'h60;
  localparam logic [7:0] DaaHighLim = 8'h99;
  localparam logic [3:0] DaaLowLim  = 4'h9;

  typedef struct packed {
    logic [4:0]        operation;
    logic [7:0]        accumulator;
    logic [7:0]        operand;
    logic [3:0]        flags_in;
    logic [15:0]       wide_left;
    logic [15:0]       wide_right;
    logic signed [7:0] offset;
  } in_t;

  typedef struct packed {
    logic [7:0]  result;
    logic [15:0] wide_result;
    logic [3:0]  flags_out;
  } out_t;

endpackage

### sv/eight_bit_alu_with_flags_top.sv
// Top level: input register, ALU datapath, result register on stream ports.
//
//  port group  dir  tdata bits  contents
//  s_axis      in   72          operation, accumulator, operand, flags_in,
//                               wide_left, wide_right, offset
//  m_axis      out  32          result, wide_result, flags_out
//
// One beat per clock sustained while m_axis accepts results; a beat passes
// the input register, then the single-pass ALU logic, then the result register.
// Reset clears both valid bits; payload registers are not reset.
// A stall on m_axis holds the result; the input register keeps taking a
// beat as long as one of the two stages can move.
`timescale 1ns / 1ps

module eight_bit_alu_with_flags_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [4:0] operation, [12:5] accumulator, [20:13] operand, [24:21] flags_in,
  // [40:25] wide_left, [56:41] wide_right, [64:57] offset, [71:65] zero
  input  logic [ealu_pkg::InTdataW-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] result, [23:8] wide_result, [27:24] flags_out, [31:28] zero
  output logic [ealu_pkg::OutTdataW-1:0]   m_axis_tdata
);
  import ealu_pkg::*;

  in_t  in_d, in_q;
  out_t res_d, res_q;
  logic in_vld_q, res_vld_q;
  logic in_rdy, res_rdy;

  assign in_d.operation   = s_axis_tdata[4:0];
  assign in_d.accumulator = s_axis_tdata[12:5];
  assign in_d.operand     = s_axis_tdata[20:13];
  assign in_d.flags_in    = s_axis_tdata[24:21];
  assign in_d.wide_left   = s_axis_tdata[40:25];
  assign in_d.wide_right  = s_axis_tdata[56:41];
  assign in_d.offset      = s_axis_tdata[64:57];

  assign res_rdy       = !res_vld_q || m_axis_tready;
  assign in_rdy        = !in_vld_q || res_rdy;
  assign s_axis_tready = in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_rdy) in_vld_q <= s_axis_tvalid;
      if (res_rdy) res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && s_axis_tvalid) in_q <= in_d;
    if (res_rdy && in_vld_q) res_q <= res_d;
  end

  ealu_core u_core (
    .op_i  (in_q),
    .res_o (res_d)
  );

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = {4'd0, res_q.flags_out, res_q.wide_result, res_q.result};

endmodule

### sv/ealu_core.sv
// Combinational ALU datapath: one operation from operands and flags.
`timescale 1ns / 1ps

module ealu_core (
  input  ealu_pkg::in_t  op_i,
  output ealu_pkg::out_t res_o
);
  import ealu_pkg::*;

  logic       cin;
  logic       use_c;
  logic [8:0] add9;
  logic [4:0] addh;
  logic [8:0] sub9;
  logic [4:0] subh;
  logic [7:0] inc8;
  logic [7:0] dec8;
  logic [7:0] daa_adj;
  logic [7:0] daa_res;
  logic [16:0] w_sum;
  logic [12:0] w_half;
  logic [15:0] sp_sum;
  logic [4:0]  sp_half;
  logic [8:0]  sp_low;
  logic [7:0]  a;
  logic [7:0]  b;
  logic [3:0]  f;

  assign a   = op_i.accumulator;
  assign b   = op_i.operand;
  assign f   = op_i.flags_in;
  assign cin = f[FlagC];

  // carry-in only for adc / sbc
  assign use_c = ((op_i.operation == OP_ADC) || (op_i.operation == OP_SBC)) ? cin : 1'b0;

  assign add9 = {1'b0, a} + {1'b0, b} + {8'd0, use_c};
  assign addh = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, use_c};
  // borrow shows as bit 8 / bit 4 of the wrapped difference
  assign sub9 = {1'b0, a} - {1'b0, b} - {8'd0, use_c};
  assign subh = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, use_c};
  assign inc8 = b + 8'd1;
  assign dec8 = b - 8'd1;

  always_comb begin
    daa_adj = 8'd0;
    if (f[FlagN]) begin
      if (f[FlagH]) daa_adj = daa_adj | DaaLowAdj;
      if (cin) daa_adj = daa_adj | DaaHighAdj;
      daa_res = a - daa_adj;
    end else begin
      if (f[FlagH] || (a[3:0] > DaaLowLim)) daa_adj = daa_adj | DaaLowAdj;
      if (cin || (a > DaaHighLim)) daa_adj = daa_adj | DaaHighAdj;
      daa_res = a + daa_adj;
    end
  end

  assign w_sum   = {1'b0, op_i.wide_left} + {1'b0, op_i.wide_right};
  assign w_half  = {1'b0, op_i.wide_left[11:0]} + {1'b0, op_i.wide_right[11:0]};
  assign sp_sum  = op_i.wide_left + {{8{op_i.offset[7]}}, op_i.offset};
  assign sp_half = {1'b0, op_i.wide_left[3:0]} + {1'b0, op_i.offset[3:0]};
  assign sp_low  = {1'b0, op_i.wide_left[7:0]} + {1'b0, op_i.offset};

  always_comb begin
    res_o.result      = a;
    res_o.wide_result = 16'd0;
    res_o.flags_out   = f;
    case (op_e'(op_i.operation))
      OP_ADD, OP_ADC: begin
        res_o.result    = add9[7:0];
        res_o.flags_out = {add9[7:0] == 8'd0, 1'b0, addh[4], add9[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        if (op_i.operation != OP_CP) res_o.result = sub9[7:0];
        res_o.flags_out = {sub9[7:0] == 8'd0, 1'b1, subh[4], sub9[8]};
      end
      OP_AND: begin
        res_o.result    = a & b;
        res_o.flags_out = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        res_o.result    = a ^ b;
        res_o.flags_out = {(a ^ b) == 8'd0, 3'b000};
      end
      OP_OR: begin
        res_o.result    = a | b;
        res_o.flags_out = {(a | b) == 8'd0, 3'b000};
      end
      OP_INC: begin
        res_o.result    = inc8;
        res_o.flags_out = {inc8 == 8'd0, 1'b0, b[3:0] == 4'hf, cin};
      end
      OP_DEC: begin
        res_o.result    = dec8;
        res_o.flags_out = {dec8 == 8'd0, 1'b1, b[3:0] == 4'h0, cin};
      end
      OP_DAA: begin
        res_o.result    = daa_res;
        res_o.flags_out = {daa_res == 8'd0, f[FlagN], 1'b0,
                           f[FlagN] ? cin : daa_adj[6]};
      end
      OP_CPL: begin
        res_o.result    = ~a;
        res_o.flags_out = {f[FlagZ], 1'b1, 1'b1, cin};
      end
      OP_CCF:  res_o.flags_out = {f[FlagZ], 2'b00, ~cin};
      OP_SCF:  res_o.flags_out = {f[FlagZ], 2'b00, 1'b1};
      OP_RLCA: begin
        res_o.result    = {a[6:0], a[7]};
        res_o.flags_out = {3'b000, a[7]};
      end
      OP_RLA: begin
        res_o.result    = {a[6:0], cin};
        res_o.flags_out = {3'b000, a[7]};
      end
      OP_RRCA: begin
        res_o.result    = {a[0], a[7:1]};
        res_o.flags_out = {3'b000, a[0]};
      end
      OP_RRA: begin
        res_o.result    = {cin, a[7:1]};
        res_o.flags_out = {3'b000, a[0]};
      end
      OP_ADD16: begin
        res_o.wide_result = w_sum[15:0];
        res_o.flags_out   = {f[FlagZ], 1'b0, w_half[12], w_sum[16]};
      end
      OP_ADDSP: begin
        res_o.wide_result = sp_sum;
        res_o.flags_out   = {2'b00, sp_half[4], sp_low[8]};
      end
      default: ;
    endcase
  end

endmodule

### sv/ealu_checker.sv
// Port-level checker for the ALU top level, bound to it.
`timescale 1ns / 1ps

module ealu_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ealu_pkg::OutTdataW-1:0] m_axis_tdata
);
  import ealu_pkg::*;

  // empty output side means nothing can back up into the input
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output empty");

  // a beat accepted while the output is empty passes the input and result registers to the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |-> ##2 m_axis_tvalid)
    else $error("result missing two cycles after accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind eight_bit_alu_with_flags_top ealu_checker u_ealu_checker (.*);

### dv/alu_flag_monitor.sv
// Watches both stream ports of the ALU, predicts each result and compares it.
`timescale 1ns / 1ps

module alu_flag_monitor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [ealu_pkg::InTdataW-1:0]  s_tdata_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [ealu_pkg::OutTdataW-1:0] m_tdata_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import ealu_pkg::*;

  out_t expected_q[$];
  int   result_count;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    result_count = 0;
  end

  function automatic logic [3:0] flag_word(input logic z, input logic n,
                                           input logic h, input logic c);
    logic [3:0] w;
    w        = '0;
    w[FlagZ] = z;
    w[FlagN] = n;
    w[FlagH] = h;
    w[FlagC] = c;
    return w;
  endfunction

  function automatic out_t alu_predict(input in_t x);
    out_t        r;
    logic [8:0]  s9;
    logic [4:0]  s5;
    logic [16:0] s17;
    logic [12:0] s13;
    logic [7:0]  adj;
    logic [7:0]  off_u;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [3:0]  f;
    logic        cin;
    logic        t;
    a             = x.accumulator;
    b             = x.operand;
    f             = x.flags_in;
    off_u         = x.offset;
    cin           = f[FlagC];
    r.result      = a;
    r.wide_result = '0;
    r.flags_out   = f;
    case (x.operation)
      OP_ADD, OP_ADC: begin
        t  = (x.operation == OP_ADC) ? cin : 1'b0;
        s9 = {1'b0, a} + {1'b0, b} + 9'(t);
        s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + 5'(t);
        r.result    = s9[7:0];
        r.flags_out = flag_word(s9[7:0] == 8'h00, 1'b0, s5[4], s9[8]);
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // borrow shows up as the sign bit of the widened difference
        t  = (x.operation == OP_SBC) ? cin : 1'b0;
        s9 = {1'b0, a} - {1'b0, b} - 9'(t);
        s5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - 5'(t);
        r.result    = (x.operation == OP_CP) ? a : s9[7:0];
        r.flags_out = flag_word(s9[7:0] == 8'h00, 1'b1, s5[4], s9[8]);
      end
      OP_AND: begin
        r.result    = a & b;
        r.flags_out = flag_word((a & b) == 8'h00, 1'b0, 1'b1, 1'b0);
      end
      OP_XOR: begin
        r.result    = a ^ b;
        r.flags_out = flag_word((a ^ b) == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_OR: begin
        r.result    = a | b;
        r.flags_out = flag_word((a | b) == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_INC: begin
        r.result    = b + 8'd1;
        r.flags_out = flag_word(r.result == 8'h00, 1'b0, b[3:0] == 4'hF, cin);
      end
      OP_DEC: begin
        r.result    = b - 8'd1;
        r.flags_out = flag_word(r.result == 8'h00, 1'b1, b[3:0] == 4'h0, cin);
      end
      OP_DAA: begin
        adj = '0;
        if (f[FlagN]) begin
          if (f[FlagH]) adj += DaaLowAdj;
          if (cin) adj += DaaHighAdj;
          r.result = a - adj;
          t        = cin;
        end else begin
          if (f[FlagH] || a[3:0] > DaaLowLim) adj += DaaLowAdj;
          if (cin || a > DaaHighLim) adj += DaaHighAdj;
          r.result = a + adj;
          t        = (adj >= DaaHighAdj);
        end
        r.flags_out = flag_word(r.result == 8'h00, f[FlagN], 1'b0, t);
      end
      OP_CPL: begin
        r.result    = ~a;
        r.flags_out = flag_word(f[FlagZ], 1'b1, 1'b1, cin);
      end
      OP_CCF:  r.flags_out = flag_word(f[FlagZ], 1'b0, 1'b0, ~cin);
      OP_SCF:  r.flags_out = flag_word(f[FlagZ], 1'b0, 1'b0, 1'b1);
      OP_RLCA: begin
        r.result    = {a[6:0], a[7]};
        r.flags_out = flag_word(1'b0, 1'b0, 1'b0, a[7]);
      end
      OP_RLA: begin
        r.result    = {a[6:0], cin};
        r.flags_out = flag_word(1'b0, 1'b0, 1'b0, a[7]);
      end
      OP_RRCA: begin
        r.result    = {a[0], a[7:1]};
        r.flags_out = flag_word(1'b0, 1'b0, 1'b0, a[0]);
      end
      OP_RRA: begin
        r.result    = {cin, a[7:1]};
        r.flags_out = flag_word(1'b0, 1'b0, 1'b0, a[0]);
      end
      OP_ADD16: begin
        s17 = {1'b0, x.wide_left} + {1'b0, x.wide_right};
        s13 = {1'b0, x.wide_left[11:0]} + {1'b0, x.wide_right[11:0]};
        r.wide_result = s17[15:0];
        r.flags_out   = flag_word(f[FlagZ], 1'b0, s13[12], s17[16]);
      end
      OP_ADDSP: begin
        // sign-extended sum, but flags come from the unsigned low byte
        r.wide_result = x.wide_left + {{8{off_u[7]}}, off_u};
        s5 = {1'b0, x.wide_left[3:0]} + {1'b0, off_u[3:0]};
        s9 = {1'b0, x.wide_left[7:0]} + {1'b0, off_u};
        r.flags_out = flag_word(1'b0, 1'b0, s5[4], s9[8]);
      end
      default: ;  // spare codes pass accumulator and flags through
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin : watch
    in_t  beat;
    out_t got;
    out_t want;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        got.result      = m_tdata_i[7:0];
        got.wide_result = m_tdata_i[23:8];
        got.flags_out   = m_tdata_i[27:24];
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with nothing pending, data %h",
                                    result_count, m_tdata_i));
        end else begin
          want = expected_q.pop_front();
          if (got.result !== want.result)
            report_mismatch($sformatf("beat %0d result %h, want %h",
                                      result_count, got.result, want.result));
          if (got.wide_result !== want.wide_result)
            report_mismatch($sformatf("beat %0d wide_result %h, want %h",
                                      result_count, got.wide_result, want.wide_result));
          if (got.flags_out !== want.flags_out)
            report_mismatch($sformatf("beat %0d flags_out %b, want %b",
                                      result_count, got.flags_out, want.flags_out));
        end
        result_count++;
      end
      if (s_tvalid_i && s_tready_i) begin
        beat.operation   = s_tdata_i[4:0];
        beat.accumulator = s_tdata_i[12:5];
        beat.operand     = s_tdata_i[20:13];
        beat.flags_in    = s_tdata_i[24:21];
        beat.wide_left   = s_tdata_i[40:25];
        beat.wide_right  = s_tdata_i[56:41];
        beat.offset      = s_tdata_i[64:57];
        expected_q.push_back(alu_predict(beat));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

### dv/eight_bit_alu_with_flags_top_tb.sv
// Top of the ALU testbench: clock, reset, stream stimulus and final verdict.
`timescale 1ns / 1ps

module eight_bit_alu_with_flags_top_tb;
  import ealu_pkg::*;

  localparam logic [4:0] OpSpareFirst  = 5'd20;
  localparam logic [4:0] OpSpareLast   = 5'd31;
  localparam int         RandomBeats   = 1825;
  localparam int         HoldOffCycles = 200;
  localparam int         IdlePct       = 26;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;

  int   mismatches;
  int   outstanding;
  logic hold_req;
  logic calm;

  eight_bit_alu_with_flags_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  alu_flag_monitor u_flag_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (mismatches),
    .pending_o    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stalls, one long hold-off, one calm stretch
  initial begin : sink
    int  hold_left;
    bit  held_once;
    hold_left     = 0;
    held_once     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held_once) begin
        hold_left = HoldOffCycles;
        held_once = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= IdlePct);
      end
    end
  end

  function automatic in_t make_beat(input logic [4:0] op, input logic [7:0] a,
                                    input logic [7:0] b, input logic [3:0] f,
                                    input logic [15:0] wl, input logic [15:0] wr,
                                    input logic [7:0] off);
    in_t x;
    x.operation   = op;
    x.accumulator = a;
    x.operand     = b;
    x.flags_in    = f;
    x.wide_left   = wl;
    x.wide_right  = wr;
    x.offset      = off;
    return x;
  endfunction

  // byte that lands on a carry or BCD boundary now and then
  function automatic logic [7:0] edgy_byte();
    logic [7:0] corners [10];
    corners = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h99, 8'h9A, 8'h80, 8'h7F, 8'h01, 8'h10};
    if ($urandom_range(99, 0) < 20) return corners[$urandom_range(9, 0)];
    return 8'($urandom);
  endfunction

  function automatic in_t random_beat();
    in_t x;
    if ($urandom_range(99, 0) < 8)
      x.operation = 5'($urandom_range(int'(OpSpareLast), int'(OpSpareFirst)));
    else
      x.operation = 5'($urandom_range(int'(OP_ADDSP), int'(OP_ADD)));
    x.accumulator = edgy_byte();
    x.operand     = edgy_byte();
    x.flags_in    = 4'($urandom);
    x.wide_left   = 16'($urandom);
    x.wide_right  = 16'($urandom);
    x.offset      = edgy_byte();
    return x;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(input in_t x);
    s_axis_tdata  <= {7'b0, x.offset, x.wide_right, x.wide_left, x.flags_in,
                      x.operand, x.accumulator, x.operation};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int i;
    bit quiet;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    hold_req      = 1'b0;
    calm          = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed corners, flags_in bits are Z N H C
    send_beat(make_beat(OP_ADD,   8'hFF, 8'h01, 4'b0000, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_ADC,   8'h0F, 8'h00, 4'b0001, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_beat(make_beat(OP_ADC,   8'hFF, 8'h00, 4'b1111, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_SUB,   8'h00, 8'h01, 4'b0000, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_SBC,   8'h10, 8'h0F, 4'b0001, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_SBC,   8'h05, 8'h05, 4'b0001, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_AND,   8'hFF, 8'h00, 4'b0000, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_XOR,   8'hAA, 8'h55, 4'b1111, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_OR,    8'h00, 8'h00, 4'b0000, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_CP,    8'h3C, 8'h3C, 4'b0000, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_INC,   8'h00, 8'hFF, 4'b0001, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_DEC,   8'h00, 8'h00, 4'b0000, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_DAA,   8'h9A, 8'h00, 4'b0000, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_DAA,   8'h00, 8'h00, 4'b0111, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_DAA,   8'h99, 8'h00, 4'b0000, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_CPL,   8'h55, 8'h00, 4'b1001, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_CCF,   8'h12, 8'h00, 4'b1111, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_SCF,   8'h34, 8'h00, 4'b0000, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_RLCA,  8'h80, 8'h00, 4'b1110, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_RLA,   8'h7F, 8'h00, 4'b0001, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_RRCA,  8'h01, 8'h00, 4'b0000, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_RRA,   8'hFE, 8'h00, 4'b0001, 16'h0000, 16'h0000, 8'h00));
    send_beat(make_beat(OP_ADD16, 8'h00, 8'h00, 4'b1000, 16'hFFFF, 16'h0001, 8'h00));
    send_beat(make_beat(OP_ADD16, 8'h00, 8'h00, 4'b0000, 16'h0FFF, 16'h0001, 8'h00));
    send_beat(make_beat(OP_ADDSP, 8'h00, 8'h00, 4'b1111, 16'h00FF, 16'h0000, 8'h80));
    send_beat(make_beat(OP_ADDSP, 8'h00, 8'h00, 4'b0000, 16'hFFFF, 16'h0000, 8'h7F));
    send_beat(make_beat(OpSpareFirst, 8'hA5, 8'h5A, 4'b1010, 16'h1234, 16'h5678, 8'h9C));
    send_beat(make_beat(OpSpareLast,  8'h5A, 8'hA5, 4'b0101, 16'hFFFF, 16'hFFFF, 8'hFF));

    for (i = 0; i < RandomBeats; i++) begin
      quiet = (i >= 600 && i < 900);
      calm <= quiet;
      if (i == 300) hold_req <= 1'b1;  // sink stalls while beats keep coming
      if (i == 1100) begin
        // let the pipe run dry before carrying on
        s_axis_tvalid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk_i);
      end else if (!quiet && $urandom_range(99, 0) < IdlePct) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(4, 1)) @(negedge clk_i);
      end
      send_beat(random_beat());
    end
    s_axis_tvalid <= 1'b0;
    calm          <= 1'b0;

    wait (outstanding == 0);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### eight_bit_alu_with_flags_top.f
sv/ealu_pkg.sv
sv/ealu_core.sv
sv/eight_bit_alu_with_flags_top.sv
sv/ealu_checker.sv
dv/alu_flag_monitor.sv
dv/eight_bit_alu_with_flags_top_tb.sv
